// ----- rtl/core/md5_stream_hasher_defines.svh -----
// assertion macros shared by the md5 stream hasher modules
// no dependencies; included by files that carry assertions
`ifndef MD5_STREAM_HASHER_DEFINES_SVH
`define MD5_STREAM_HASHER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MD5SH_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define MD5SH_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/md5sh_pkg.sv -----
// shared types, mode codes and round tables of the md5 stream hasher
// no dependencies
package md5sh_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [1:0] MODE_APPEND = 2'd0;
    localparam logic [1:0] MODE_FINISH = 2'd1;
    localparam logic [1:0] MODE_FLUSH  = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [1:0] mode;
    } md5sh_in_t;

    typedef struct packed {
        logic [31:0] digest_word_a;
        logic [31:0] digest_word_b;
        logic [31:0] digest_word_c;
        logic [31:0] digest_word_d;
    } md5sh_out_t;

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k;
        case (idx)
            6'd0:  k = 32'hd76aa478;
            6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;
            6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;
            6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;
            6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;
            6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;
            6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;
            6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;
            6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;
            6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;
            6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;
            6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;
            6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;
            6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;
            6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;
            6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;
            6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;
            6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;
            6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;
            6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;
            6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;
            6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;
            6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;
            6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;
            6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;
            6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;
            6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;
            6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;
            6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;
            6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;
            6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;
            6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;
            6'd63: k = 32'heb86d391;
            default: k = '0;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] round_s(input logic [5:0] idx);
        logic [4:0] s;
        case ({idx[5:4], idx[1:0]})
            4'd0:  s = 5'd7;
            4'd1:  s = 5'd12;
            4'd2:  s = 5'd17;
            4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;
            4'd5:  s = 5'd9;
            4'd6:  s = 5'd14;
            4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;
            4'd9:  s = 5'd11;
            4'd10: s = 5'd16;
            4'd11: s = 5'd23;
            4'd12: s = 5'd6;
            4'd13: s = 5'd10;
            4'd14: s = 5'd15;
            4'd15: s = 5'd21;
            default: s = '0;
        endcase
        return s;
    endfunction

    // message word used by a round: a formula on the low four index bits, picked by the top two
    function automatic logic [3:0] msg_index(input logic [5:0] idx);
        logic [3:0] i4;
        logic [3:0] g;
        i4 = idx[3:0];
        case (idx[5:4])
            2'd0: g = i4;
            2'd1: g = 4'(i4 * 4'd5 + 4'd1);
            2'd2: g = 4'(i4 * 4'd3 + 4'd5);
            2'd3: g = 4'(i4 * 4'd7);
            default: g = i4;
        endcase
        return g;
    endfunction

endpackage

// ----- rtl/core/md5_stream_hasher.sv -----
// Streaming MD5 hasher. A request carries one byte and a mode (append, append
// and finish, finish only); mode 3 is dropped. Requests enter a queue of
// QUEUE_DEPTH entries at one per cycle while it is not full, and the core takes
// one byte per cycle into the 64-byte block while it is idle. Each full block
// passes 64 rounds through the single round unit and then the chaining add.
// A finish writes padding and length bytes up to the block end, runs one or two
// compressions and loads the digest register, which lets the next message load
// while the digest waits to be taken.
// depends on md5sh_pkg, md5sh_front and md5sh_core
module md5_stream_hasher #(
    parameter int QUEUE_DEPTH = md5sh_pkg::QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  data_valid,
    output logic                  data_ready,
    input  md5sh_pkg::md5sh_in_t  data,
    output logic                  digest_valid,
    input  logic                  digest_ready,
    output md5sh_pkg::md5sh_out_t digest
);

    logic                 q_valid;
    logic                 q_ready;
    md5sh_pkg::md5sh_in_t q_item;

    md5sh_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_valid (data_valid),
        .data_ready (data_ready),
        .data       (data),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_item     (q_item)
    );

    md5sh_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_item       (q_item),
        .digest_valid (digest_valid),
        .digest_ready (digest_ready),
        .digest       (digest)
    );

endmodule

// ----- rtl/core/md5sh_front.sv -----
// request queue of the md5 stream hasher: accepts requests, drops unused modes
// depends on md5sh_pkg and md5_stream_hasher_defines.svh
`include "md5_stream_hasher_defines.svh"

module md5sh_front #(
    parameter int DEPTH = md5sh_pkg::QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  data_valid,
    output logic                  data_ready,
    input  md5sh_pkg::md5sh_in_t  data,
    output logic                  q_valid,
    input  logic                  q_ready,
    output md5sh_pkg::md5sh_in_t  q_item
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    md5sh_pkg::md5sh_in_t mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          push;
    logic          pop;

    assign data_ready = (cnt_reg != CW'(DEPTH));
    assign push       = data_valid && data_ready && (data.mode != md5sh_pkg::MODE_UNUSED);
    assign q_valid    = (cnt_reg != '0);
    assign q_item     = mem_reg[rd_ptr_reg];
    assign pop        = q_valid && q_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_reg + 1'b1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_reg + 1'b1);
        end
        if (push && !pop)
        begin
            cnt_next = CW'(cnt_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            cnt_next = CW'(cnt_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= data;
        end
    end

    `MD5SH_ASSERT_NEXT(a_fill_up, clk, rst_n, push && !pop, cnt_reg == CW'($past(cnt_reg) + 1'b1), "queue count did not rise on push")
    `MD5SH_ASSERT_NEXT(a_drain, clk, rst_n, pop && !push, cnt_reg == CW'($past(cnt_reg) - 1'b1), "queue count did not fall on pop")
    `MD5SH_ASSERT_IMP(a_no_unused, clk, rst_n, q_valid, q_item.mode != md5sh_pkg::MODE_UNUSED, "unused mode reached the core")

endmodule

// ----- rtl/core/md5sh_core.sv -----
// block buffer, padding sequencer and one-round-per-cycle md5 compression
// depends on md5sh_pkg and md5_stream_hasher_defines.svh
`include "md5_stream_hasher_defines.svh"

module md5sh_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    output logic                  q_ready,
    input  md5sh_pkg::md5sh_in_t  q_item,
    output logic                  digest_valid,
    input  logic                  digest_ready,
    output md5sh_pkg::md5sh_out_t digest
);

    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [5:0] LAST_POS   = 6'd63;
    localparam logic [5:0] LEN_POS    = 6'd55;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROUND,
        S_ADD,
        S_PAD,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        PAD_MARK,
        PAD_ZERO,
        PAD_LEN
    } pad_t;

    state_t      state_reg, state_next;
    pad_t        pad_reg, pad_next;
    logic        fin_reg, fin_next;
    logic        done_reg, done_next;
    logic        out_valid_reg, out_valid_next;
    logic [5:0]  round_reg, round_next;
    logic [5:0]  wr_pos_reg, wr_pos_next;
    logic [63:0] bit_cnt_reg, bit_cnt_next;
    logic [31:0] chain_reg [4];
    logic [31:0] chain_next [4];

    logic [31:0] blk_reg [16];
    logic [31:0] a_reg, a_next, b_reg, b_next, c_reg, c_next, d_reg, d_next;
    md5sh_pkg::md5sh_out_t out_reg, out_next;

    logic        wr_en;
    logic [7:0]  wr_byte;
    logic        has_byte;
    logic        finish;
    logic [31:0] f;
    logic [31:0] sum;
    logic [63:0] dbl;
    logic [31:0] rot;

    // one md5 round
    always_comb
    begin
        case (round_reg[5:4])
            2'd0:    f = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd1:    f = (b_reg & d_reg) | (c_reg & ~d_reg);
            2'd2:    f = b_reg ^ c_reg ^ d_reg;
            2'd3:    f = c_reg ^ (b_reg | ~d_reg);
            default: f = '0;
        endcase
        sum = a_reg + f + md5sh_pkg::round_k(round_reg)
            + blk_reg[md5sh_pkg::msg_index(round_reg)];
        dbl = {sum, sum} << md5sh_pkg::round_s(round_reg);
        rot = dbl[63:32];
    end

    assign has_byte = (q_item.mode == md5sh_pkg::MODE_APPEND)
                   || (q_item.mode == md5sh_pkg::MODE_FINISH);
    assign finish   = (q_item.mode == md5sh_pkg::MODE_FINISH)
                   || (q_item.mode == md5sh_pkg::MODE_FLUSH);
    assign q_ready  = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        pad_next       = pad_reg;
        fin_next       = fin_reg;
        done_next      = done_reg;
        out_valid_next = out_valid_reg && !digest_ready;
        round_next     = round_reg;
        wr_pos_next    = wr_pos_reg;
        bit_cnt_next   = bit_cnt_reg;
        chain_next     = chain_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        d_next         = d_reg;
        out_next       = out_reg;
        wr_en          = 1'b0;
        wr_byte        = q_item.data_byte;

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    fin_next  = finish;
                    done_next = 1'b0;
                    pad_next  = PAD_MARK;
                    if (has_byte)
                    begin
                        wr_en        = 1'b1;
                        wr_pos_next  = 6'(wr_pos_reg + 1'b1);
                        bit_cnt_next = 64'(bit_cnt_reg + 64'd8);
                    end
                    if (has_byte && (wr_pos_reg == LAST_POS))
                    begin
                        state_next = S_ROUND;
                        round_next = '0;
                        a_next     = chain_reg[0];
                        b_next     = chain_reg[1];
                        c_next     = chain_reg[2];
                        d_next     = chain_reg[3];
                    end
                    else if (finish)
                    begin
                        state_next = S_PAD;
                    end
                end
            end
            S_PAD:
            begin
                wr_en       = 1'b1;
                wr_pos_next = 6'(wr_pos_reg + 1'b1);
                case (pad_reg)
                    PAD_MARK: wr_byte = 8'h80;
                    PAD_ZERO: wr_byte = 8'h00;
                    PAD_LEN:  wr_byte = bit_cnt_reg[{wr_pos_reg[2:0], 3'b000} +: 8];
                    default:  wr_byte = 8'h00;
                endcase
                if ((pad_reg != PAD_LEN) && (wr_pos_reg == LEN_POS))
                begin
                    pad_next = PAD_LEN;
                end
                else if (pad_reg == PAD_MARK)
                begin
                    pad_next = PAD_ZERO;
                end
                if (wr_pos_reg == LAST_POS)
                begin
                    done_next  = (pad_reg == PAD_LEN);
                    state_next = S_ROUND;
                    round_next = '0;
                    a_next     = chain_reg[0];
                    b_next     = chain_reg[1];
                    c_next     = chain_reg[2];
                    d_next     = chain_reg[3];
                end
            end
            S_ROUND:
            begin
                a_next     = d_reg;
                d_next     = c_reg;
                c_next     = b_reg;
                b_next     = b_reg + rot;
                round_next = 6'(round_reg + 1'b1);
                if (round_reg == LAST_ROUND)
                begin
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                chain_next[0] = chain_reg[0] + a_reg;
                chain_next[1] = chain_reg[1] + b_reg;
                chain_next[2] = chain_reg[2] + c_reg;
                chain_next[3] = chain_reg[3] + d_reg;
                if (done_reg)
                begin
                    state_next = S_OUT;
                end
                else if (fin_reg)
                begin
                    state_next = S_PAD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || digest_ready)
                begin
                    out_valid_next        = 1'b1;
                    out_next.digest_word_a = chain_reg[0];
                    out_next.digest_word_b = chain_reg[1];
                    out_next.digest_word_c = chain_reg[2];
                    out_next.digest_word_d = chain_reg[3];
                    chain_next[0]         = md5sh_pkg::INIT_A;
                    chain_next[1]         = md5sh_pkg::INIT_B;
                    chain_next[2]         = md5sh_pkg::INIT_C;
                    chain_next[3]         = md5sh_pkg::INIT_D;
                    bit_cnt_next          = '0;
                    fin_next              = 1'b0;
                    done_next             = 1'b0;
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pad_reg       <= PAD_MARK;
            fin_reg       <= 1'b0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            round_reg     <= '0;
            wr_pos_reg    <= '0;
            bit_cnt_reg   <= '0;
            chain_reg[0]  <= md5sh_pkg::INIT_A;
            chain_reg[1]  <= md5sh_pkg::INIT_B;
            chain_reg[2]  <= md5sh_pkg::INIT_C;
            chain_reg[3]  <= md5sh_pkg::INIT_D;
            a_reg         <= '0;
            b_reg         <= '0;
            c_reg         <= '0;
            d_reg         <= '0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            pad_reg       <= pad_next;
            fin_reg       <= fin_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
            round_reg     <= round_next;
            wr_pos_reg    <= wr_pos_next;
            bit_cnt_reg   <= bit_cnt_next;
            chain_reg     <= chain_next;
            a_reg         <= a_next;
            b_reg         <= b_next;
            c_reg         <= c_next;
            d_reg         <= d_next;
            out_reg       <= out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            blk_reg[wr_pos_reg[5:2]][{wr_pos_reg[1:0], 3'b000} +: 8] <= wr_byte;
        end
    end

    assign digest_valid = out_valid_reg;
    assign digest       = out_reg;

    `MD5SH_ASSERT_NEXT(a_round_step, clk, rst_n, (state_reg == S_ROUND) && (round_reg != LAST_ROUND), (state_reg == S_ROUND) && (round_reg == 6'($past(round_reg) + 1'b1)), "round counter skipped")
    `MD5SH_ASSERT_IMP(a_pos_tracks, clk, rst_n, state_reg == S_IDLE, wr_pos_reg == bit_cnt_reg[8:3], "write position lost track of byte count")
    `MD5SH_ASSERT_IMP(a_out_aligned, clk, rst_n, state_reg == S_OUT, (wr_pos_reg == '0) && done_reg, "digest without a closed padded block")
    `MD5SH_ASSERT_NEXT(a_full_block, clk, rst_n, (state_reg == S_PAD) && (wr_pos_reg == LAST_POS), state_reg == S_ROUND, "full block not compressed")

endmodule

// ----- dv/md5_stream_hasher_checker.sv -----
// digest checker for the md5 stream hasher: predicts every digest from the accepted requests
// and compares it with the digests taken from the block
// depends on md5sh_pkg
module md5_stream_hasher_checker (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  data_valid,
    input  logic                  data_ready,
    input  md5sh_pkg::md5sh_in_t  data,
    input  logic                  digest_valid,
    input  logic                  digest_ready,
    input  md5sh_pkg::md5sh_out_t digest,
    output int                    fail_count,
    output int                    pending
);
    import md5sh_pkg::*;

    localparam logic [0:63][31:0] SINE_K = {
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [0:15][4:0] ROT_S = {
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    logic [31:0] chain [4];
    logic [31:0] blk [16];
    logic [63:0] msg_bits;
    md5sh_out_t  expected_digests [$];
    int          errs;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int s);
        return (x << s) | (x >> (32 - s));
    endfunction

    function automatic void restart_chain();
        chain[0] = INIT_A;
        chain[1] = INIT_B;
        chain[2] = INIT_C;
        chain[3] = INIT_D;
        msg_bits = '0;
    endfunction

    function automatic void compress_block();
        logic [31:0] a, b, c, d, f, t;
        logic [3:0]  g;
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        for (int i = 0; i < 64; i++)
        begin
            case (i / 16)
                0:
                begin
                    f = (b & c) | (~b & d);
                    g = 4'(i);
                end
                1:
                begin
                    f = (b & d) | (c & ~d);
                    g = 4'(5 * i + 1);
                end
                2:
                begin
                    f = b ^ c ^ d;
                    g = 4'(3 * i + 5);
                end
                default:
                begin
                    f = c ^ (b | ~d);
                    g = 4'(7 * i);
                end
            endcase
            t = d;
            d = c;
            c = b;
            b = b + rotl(a + f + SINE_K[i] + blk[g], int'(ROT_S[(i / 16) * 4 + i % 4]));
            a = t;
        end
        chain[0] += a;
        chain[1] += b;
        chain[2] += c;
        chain[3] += d;
    endfunction

    function automatic void place_byte(input logic [5:0] pos, input logic [7:0] b);
        blk[pos[5:2]][8 * pos[1:0] +: 8] = b;
        if (pos == 6'd63)
            compress_block();
    endfunction

    // returns 1 when the request finishes a message, with its digest in res
    function automatic bit absorb_request(input md5sh_in_t req, output md5sh_out_t res);
        logic [5:0]  pos;
        logic [63:0] len_bits;
        res = '0;
        if (req.mode == MODE_UNUSED)
            return 1'b0;
        if (req.mode != MODE_FLUSH)
        begin
            place_byte(msg_bits[8:3], req.data_byte);
            msg_bits += 64'd8;
        end
        if (req.mode == MODE_APPEND)
            return 1'b0;
        len_bits = msg_bits;
        pos = msg_bits[8:3];
        place_byte(pos, 8'h80);
        pos++;
        while (pos != 6'd56)
        begin
            place_byte(pos, 8'h00);
            pos++;
        end
        for (int k = 0; k < 8; k++)
            place_byte(6'(56 + k), len_bits[8 * k +: 8]);
        res = {chain[0], chain[1], chain[2], chain[3]};
        restart_chain();
        return 1'b1;
    endfunction

    function automatic void check_word(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %08h, got %08h", name, want, got);
            errs++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        md5sh_out_t want;
        if (!rst_n)
        begin
            restart_chain();
            for (int w = 0; w < 16; w++)
                blk[w] = '0;
            expected_digests.delete();
            errs = 0;
            fail_count <= 0;
            pending <= 0;
        end
        else
        begin
            if (digest_valid && digest_ready)
            begin
                if (expected_digests.size() == 0)
                begin
                    $error("digest %032h arrived with none expected", digest);
                    errs++;
                end
                else
                begin
                    want = expected_digests.pop_front();
                    check_word("digest_word_a", want.digest_word_a, digest.digest_word_a);
                    check_word("digest_word_b", want.digest_word_b, digest.digest_word_b);
                    check_word("digest_word_c", want.digest_word_c, digest.digest_word_c);
                    check_word("digest_word_d", want.digest_word_d, digest.digest_word_d);
                end
            end
            if (data_valid && data_ready && absorb_request(data, want))
                expected_digests.push_back(want);
            pending <= expected_digests.size();
            fail_count <= errs;
        end
    end

endmodule

// ----- dv/md5_stream_hasher_tb.sv -----
// top of the md5 stream hasher testbench: clock, reset, request stimulus, digest stalls
// and the verdict; checking lives in md5_stream_hasher_checker
// depends on md5sh_pkg, md5_stream_hasher and md5_stream_hasher_checker
module md5_stream_hasher_tb;
    import md5sh_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASE_ITEMS = 110;
    localparam int HOLD_CYCLES = 400;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       data_valid = 1'b0;
    logic       data_ready;
    md5sh_in_t  data = '0;
    logic       digest_valid;
    logic       digest_ready = 1'b0;
    md5sh_out_t digest;

    int fail_count;
    int pending;
    int cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_gen = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int sent_items = 0;

    md5_stream_hasher dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .data_valid   (data_valid),
        .data_ready   (data_ready),
        .data         (data),
        .digest_valid (digest_valid),
        .digest_ready (digest_ready),
        .digest       (digest)
    );

    md5_stream_hasher_checker digest_chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .data_valid   (data_valid),
        .data_ready   (data_ready),
        .data         (data),
        .digest_valid (digest_valid),
        .digest_ready (digest_ready),
        .digest       (digest),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // digest side: random stalls, plus a long hold-off whenever hold_gen moves
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digest_ready <= 1'b0;
            hold_left = 0;
        end
        else if (hold_gen != hold_seen)
        begin
            hold_seen = hold_gen;
            hold_left = HOLD_CYCLES;
            digest_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            digest_ready <= 1'b0;
        end
        else
            digest_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_req(input logic [7:0] b, input logic [1:0] m);
        if ($urandom_range(99) < send_idle_pct)
        begin
            data_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        data_valid <= 1'b1;
        data <= '{data_byte: b, mode: m};
        do
            @(posedge clk);
        while (!data_ready);
        if (m != MODE_UNUSED)
            sent_items++;
    endtask

    // one message of len bytes, closed by a finish on the last byte or a finish-only request
    task automatic send_message(input int len, input bit flush_end);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(99) < 4)
                send_req(8'($urandom), MODE_UNUSED);
            send_req(8'($urandom), (i == len - 1 && !flush_end) ? MODE_FINISH : MODE_APPEND);
        end
        if (flush_end || len == 0)
            send_req(8'($urandom), MODE_FLUSH);
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return $urandom_range(12);
        if (r < 85)
            return $urandom_range(70, 13);
        case ($urandom_range(9))
            0: return 55;
            1: return 56;
            2: return 57;
            3: return 63;
            4: return 64;
            5: return 65;
            6: return 119;
            7: return 120;
            8: return 127;
            default: return 128;
        endcase
    endfunction

    task automatic wait_all_digests();
        data_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty message, ignored mode, short messages, extreme bytes
        send_req(8'hff, MODE_FLUSH);
        send_req(8'hff, MODE_UNUSED);
        send_req(8'h61, MODE_APPEND);
        send_req(8'h62, MODE_APPEND);
        send_req(8'h63, MODE_FINISH);
        send_req(8'hff, MODE_FINISH);
        send_req(8'h00, MODE_APPEND);
        send_req(8'hff, MODE_FLUSH);
        send_req(8'h12, MODE_APPEND);
        send_req(8'h00, MODE_UNUSED);
        send_req(8'h34, MODE_FINISH);
        send_req(8'h00, MODE_FINISH);
        wait_all_digests();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct <= 0;
                end
                1:
                begin
                    send_idle_pct = 80;
                    recv_stall_pct <= 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct <= 80;
                end
                default:
                begin
                    send_idle_pct = 32;
                    recv_stall_pct <= 32;
                end
            endcase
            sent_items = 0;
            while (sent_items < PHASE_ITEMS)
                send_message(pick_len(), $urandom_range(3) == 0);
            wait_all_digests();
        end

        // long digest hold-off while short messages keep coming, then a full drain
        send_idle_pct = 0;
        recv_stall_pct <= 0;
        hold_gen <= hold_gen + 1;
        for (int n = 0; n < 12; n++)
            send_message($urandom_range(8), $urandom_range(1) == 1);
        wait_all_digests();

        repeat (200) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
